@@ design/dhfk_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhfk_pkg
// Shared types, fixed-point constants and helpers of the DH kinematics chain.
// ----------------------------------------------------------------------------
package dhfk_pkg;

  // Fraction bits of rotation values and CORDIC step count
  localparam int ROT_FRAC_BITS = 30;
  localparam int CORDIC_STEPS  = 24;

  // Angle / CORDIC datapath word and full product word
  typedef logic signed [33:0] ang_t;
  typedef logic signed [67:0] prod_t;
  typedef logic signed [31:0] word_t;

  localparam ang_t PI_Q28          = 34'sd843314857;
  localparam ang_t TWO_PI_Q28      = 34'sd1686629713;
  localparam ang_t HALF_PI_Q28     = 34'sd421657428;
  localparam ang_t CORDIC_GAIN_Q30 = 34'sd652032874;

  // 1.0 in rotation format
  localparam ang_t  ONE_ROT = 34'sd1 <<< ROT_FRAC_BITS;
  localparam word_t ONE_W   = word_t'(ONE_ROT);

  // Product rounding, half up
  localparam prod_t RND_HALF = 68'sd1 <<< (ROT_FRAC_BITS - 1);

  // CORDIC output rounding from Q.30 to rotation format
  localparam int   CORD_SH   = 30 - ROT_FRAC_BITS;
  localparam ang_t CORD_HALF = (34'sd1 <<< CORD_SH) >>> 1;

  // Matrix column that carries the position
  localparam logic [1:0] COL_POS = 2'd3;

  // Link transform products
  typedef enum logic [2:0] {
    LNK_L01 = 3'd0,
    LNK_L02 = 3'd1,
    LNK_L11 = 3'd2,
    LNK_L12 = 3'd3,
    LNK_LT0 = 3'd4,
    LNK_LT1 = 3'd5
  } link_op_t;

  // Controller to datapath
  typedef struct packed {
    logic       in_ready;
    logic       emit;
    logic       emit_kind;
    logic       emit_last;
    logic [1:0] emit_row;
    logic       cord_start;
    logic       cord_sel;
    logic       mul_en;
    logic       mul_link;
    link_op_t   link_idx;
    logic [1:0] col;
    logic [1:0] term;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic cord_done;
    logic last_joint;
  } dp_status_t;

  function automatic ang_t atan_q30(input logic [4:0] idx);
    ang_t v;
    case (idx)
      5'd0:  v = 34'sd843314857;
      5'd1:  v = 34'sd497837829;
      5'd2:  v = 34'sd263043837;
      5'd3:  v = 34'sd133525159;
      5'd4:  v = 34'sd67021687;
      5'd5:  v = 34'sd33543516;
      5'd6:  v = 34'sd16775851;
      5'd7:  v = 34'sd8388437;
      5'd8:  v = 34'sd4194283;
      5'd9:  v = 34'sd2097149;
      5'd10: v = 34'sd1048576;
      5'd11: v = 34'sd524288;
      5'd12: v = 34'sd262144;
      5'd13: v = 34'sd131072;
      5'd14: v = 34'sd65536;
      5'd15: v = 34'sd32768;
      5'd16: v = 34'sd16384;
      5'd17: v = 34'sd8192;
      5'd18: v = 34'sd4096;
      5'd19: v = 34'sd2048;
      5'd20: v = 34'sd1024;
      5'd21: v = 34'sd512;
      5'd22: v = 34'sd256;
      5'd23: v = 34'sd128;
      5'd24: v = 34'sd64;
      5'd25: v = 34'sd32;
      5'd26: v = 34'sd16;
      5'd27: v = 34'sd8;
      5'd28: v = 34'sd4;
      5'd29: v = 34'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic word_t sat32(input prod_t v);
    word_t r;
    if (v > 68'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -68'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic prod_t rnd_rot(input prod_t v);
    return (v + RND_HALF) >>> ROT_FRAC_BITS;
  endfunction

endpackage

@@ design/dhfk_intf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhfk_intf
// Valid/ready channels for joint words and frame row words.
// ----------------------------------------------------------------------------
interface dhfk_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] link_offset;
  logic signed [31:0] link_length;
  logic signed [31:0] link_twist;
  logic signed [31:0] angle_offset;
  logic signed [31:0] joint_angle;
  logic               first_joint;
  logic               last_joint;

  modport source (output valid, link_offset, link_length, link_twist, angle_offset,
                  joint_angle, first_joint, last_joint, input ready);
  modport sink (input valid, link_offset, link_length, link_twist, angle_offset,
                joint_angle, first_joint, last_joint, output ready);
endinterface

interface dhfk_out_if;
  logic               valid;
  logic               ready;
  logic               frame_kind;
  logic [1:0]         row_index;
  logic signed [31:0] col0;
  logic signed [31:0] col1;
  logic signed [31:0] col2;
  logic signed [31:0] col3;
  logic               last_result;

  modport source (output valid, frame_kind, row_index, col0, col1, col2, col3,
                  last_result, input ready);
  modport sink (input valid, frame_kind, row_index, col0, col1, col2, col3,
                last_result, output ready);
endinterface

@@ design/dhfk_cordic.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhfk_cordic
// Serial rotation-mode CORDIC: folds the angle, then one step per cycle.
// ----------------------------------------------------------------------------
module dhfk_cordic
  import dhfk_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  ang_t angle,
  output logic done,
  output ang_t cos_o,
  output ang_t sin_o
);

  typedef enum logic [3:0] {
    C_IDLE = 4'b0001,
    C_FOLD = 4'b0010,
    C_ITER = 4'b0100,
    C_DONE = 4'b1000
  } cstate_t;

  cstate_t    state_r, state_nxt;
  ang_t       ang_r, ang_nxt;
  ang_t       x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic       neg_r, neg_nxt;
  logic [4:0] i_r, i_nxt;
  ang_t       dx, dy, xo, yo;

  // Shifted cross terms of the current step
  assign dx = y_r >>> i_r;
  assign dy = x_r >>> i_r;

  always_comb begin
    state_nxt = state_r;
    ang_nxt   = ang_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    neg_nxt   = neg_r;
    i_nxt     = i_r;
    unique case (state_r)
      C_IDLE: begin
        if (start) begin
          ang_nxt   = angle;
          state_nxt = C_FOLD;
        end
      end
      C_FOLD: begin
        // Bring into [-pi, pi], then into [-pi/2, pi/2]
        if (ang_r > PI_Q28) begin
          ang_nxt = ang_r - TWO_PI_Q28;
        end else if (ang_r < -PI_Q28) begin
          ang_nxt = ang_r + TWO_PI_Q28;
        end else begin
          x_nxt     = CORDIC_GAIN_Q30;
          y_nxt     = '0;
          i_nxt     = '0;
          state_nxt = C_ITER;
          if (ang_r > HALF_PI_Q28) begin
            z_nxt   = (ang_r - PI_Q28) <<< 2;
            neg_nxt = 1'b1;
          end else if (ang_r < -HALF_PI_Q28) begin
            z_nxt   = (ang_r + PI_Q28) <<< 2;
            neg_nxt = 1'b1;
          end else begin
            z_nxt   = ang_r <<< 2;
            neg_nxt = 1'b0;
          end
        end
      end
      C_ITER: begin
        if (!z_r[33]) begin
          x_nxt = x_r - dx;
          y_nxt = y_r + dy;
          z_nxt = z_r - atan_q30(i_r);
        end else begin
          x_nxt = x_r + dx;
          y_nxt = y_r - dy;
          z_nxt = z_r + atan_q30(i_r);
        end
        i_nxt = i_r + 5'd1;
        if (i_r == 5'(CORDIC_STEPS - 1)) begin
          state_nxt = C_DONE;
        end
      end
      C_DONE: begin
        state_nxt = C_IDLE;
      end
      default: begin
        state_nxt = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ang_r <= ang_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
    neg_r <= neg_nxt;
    i_r   <= i_nxt;
  end

  // Undo the half-turn fold and round to rotation format
  assign xo    = neg_r ? -x_r : x_r;
  assign yo    = neg_r ? -y_r : y_r;
  assign cos_o = (xo + CORD_HALF) >>> CORD_SH;
  assign sin_o = (yo + CORD_HALF) >>> CORD_SH;
  assign done  = (state_r == C_DONE);

endmodule

@@ design/dhfk_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhfk_ctrl
// Sequencer: emits rows, runs both CORDIC passes and the product schedule.
// ----------------------------------------------------------------------------
module dhfk_ctrl
  import dhfk_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  dp_status_t sts,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_EMIT_PRE = 10'b0000000010,
    S_CT_GO    = 10'b0000000100,
    S_CT_WAIT  = 10'b0000001000,
    S_CA_GO    = 10'b0000010000,
    S_CA_WAIT  = 10'b0000100000,
    S_LINK     = 10'b0001000000,
    S_FRAME    = 10'b0010000000,
    S_DRAIN    = 10'b0100000000,
    S_EMIT_END = 10'b1000000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  link_op_t   link_r, link_nxt;
  logic [1:0] col_r, col_nxt;
  logic [1:0] term_r, term_nxt;
  logic [1:0] term_end;

  assign term_end = (col_r == COL_POS) ? 2'd3 : 2'd2;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    link_nxt  = link_r;
    col_nxt   = col_r;
    term_nxt  = term_r;
    cmd.emit_row = cnt_r;
    cmd.link_idx = link_r;
    cmd.col      = col_r;
    cmd.term     = term_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_valid) begin
          cnt_nxt   = '0;
          state_nxt = S_EMIT_PRE;
        end
      end
      S_EMIT_PRE: begin
        // Frame before this joint
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = !sts.last_joint && (cnt_r == 2'd2);
          if (cnt_r == 2'd2) begin
            state_nxt = S_CT_GO;
          end else begin
            cnt_nxt = cnt_r + 2'd1;
          end
        end
      end
      S_CT_GO: begin
        cmd.cord_start = 1'b1;
        state_nxt      = S_CT_WAIT;
      end
      S_CT_WAIT: begin
        if (sts.cord_done) begin
          state_nxt = S_CA_GO;
        end
      end
      S_CA_GO: begin
        cmd.cord_start = 1'b1;
        cmd.cord_sel   = 1'b1;
        state_nxt      = S_CA_WAIT;
      end
      S_CA_WAIT: begin
        if (sts.cord_done) begin
          link_nxt  = LNK_L01;
          state_nxt = S_LINK;
        end
      end
      S_LINK: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_link = 1'b1;
        if (link_r == LNK_LT1) begin
          col_nxt   = '0;
          term_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = S_FRAME;
        end else begin
          link_nxt = link_op_t'(link_r + 3'd1);
        end
      end
      S_FRAME: begin
        // One product per cycle on the current top row
        cmd.mul_en = 1'b1;
        if (term_r == term_end) begin
          term_nxt = '0;
          if (col_r == COL_POS) begin
            state_nxt = S_DRAIN;
          end else begin
            col_nxt = col_r + 2'd1;
          end
        end else begin
          term_nxt = term_r + 2'd1;
        end
      end
      S_DRAIN: begin
        // Last product of the row lands and the rows advance
        col_nxt = '0;
        if (cnt_r == 2'd2) begin
          cnt_nxt   = '0;
          state_nxt = sts.last_joint ? S_EMIT_END : S_IDLE;
        end else begin
          cnt_nxt   = cnt_r + 2'd1;
          state_nxt = S_FRAME;
        end
      end
      S_EMIT_END: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = 1'b1;
          cmd.emit_last = (cnt_r == 2'd2);
          if (cnt_r == 2'd2) begin
            state_nxt = S_IDLE;
          end else begin
            cnt_nxt = cnt_r + 2'd1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      link_r  <= LNK_L01;
      col_r   <= '0;
      term_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      link_r  <= link_nxt;
      col_r   <= col_nxt;
      term_r  <= term_nxt;
    end
  end

endmodule

@@ design/dhfk_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhfk_datapath
// Frame store, CORDIC, shared multiplier with accumulate, output register.
// ----------------------------------------------------------------------------
module dhfk_datapath
  import dhfk_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  dhfk_in_if.sink    in_ch,
  dhfk_out_if.source out_ch,
  input  ctrl_cmd_t  cmd,
  output dp_status_t sts
);

  word_t      frm_r [0:2][0:3];
  word_t      nrow_r [0:2];
  word_t      d_r, a_r, lt0_r, lt1_r;
  ang_t       th_r, al_r;
  ang_t       ct_r, st_r, ca_r, sa_r;
  ang_t       l01_r, l02_r, l11_r, l12_r;
  logic       last_r, sel_r;
  prod_t      prod_r, acc_r;
  logic       wb_v_r, wb_link_r;
  link_op_t   wb_op_r;
  logic [1:0] wb_col_r, wb_term_r;
  logic       out_v_r, kind_r, olast_r;
  logic [1:0] row_r;
  word_t      oc0_r, oc1_r, oc2_r, oc3_r;

  logic  accept, cord_done, row_done;
  ang_t  cord_cos, cord_sin, op_a, op_b;
  prod_t prod_nxt, prnd, wb_base, wb_sum;

  assign accept      = in_ch.valid & cmd.in_ready;
  assign in_ch.ready = cmd.in_ready;

  assign sts.in_valid   = in_ch.valid;
  assign sts.out_free   = !out_v_r || out_ch.ready;
  assign sts.cord_done  = cord_done;
  assign sts.last_joint = last_r;

  // Latch the joint
  always_ff @(posedge clk) begin
    if (accept) begin
      d_r    <= in_ch.link_offset;
      a_r    <= in_ch.link_length;
      al_r   <= ang_t'(in_ch.link_twist);
      th_r   <= ang_t'(in_ch.angle_offset) + ang_t'(in_ch.joint_angle);
      last_r <= in_ch.last_joint;
    end
  end

  // Sine and cosine of theta, then of alpha
  dhfk_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.cord_start),
    .angle (cmd.cord_sel ? al_r : th_r),
    .done  (cord_done),
    .cos_o (cord_cos),
    .sin_o (cord_sin)
  );

  always_ff @(posedge clk) begin
    if (cmd.cord_start) begin
      sel_r <= cmd.cord_sel;
    end
    if (cord_done) begin
      if (sel_r) begin
        ca_r <= cord_cos;
        sa_r <= cord_sin;
      end else begin
        ct_r <= cord_cos;
        st_r <= cord_sin;
      end
    end
  end

  // Operand select: link terms, then top frame row times link column
  always_comb begin
    op_a = '0;
    op_b = '0;
    if (cmd.mul_link) begin
      case (cmd.link_idx)
        LNK_L01: begin op_a = st_r;         op_b = ca_r; end
        LNK_L02: begin op_a = st_r;         op_b = sa_r; end
        LNK_L11: begin op_a = ct_r;         op_b = ca_r; end
        LNK_L12: begin op_a = ct_r;         op_b = sa_r; end
        LNK_LT0: begin op_a = ang_t'(a_r);  op_b = ct_r; end
        LNK_LT1: begin op_a = ang_t'(a_r);  op_b = st_r; end
        default: begin op_a = '0;           op_b = '0;   end
      endcase
    end else begin
      op_a = ang_t'(frm_r[0][cmd.term]);
      case (cmd.col)
        2'd0: begin
          case (cmd.term)
            2'd0:    op_b = ct_r;
            2'd1:    op_b = st_r;
            default: op_b = '0;
          endcase
        end
        2'd1: begin
          case (cmd.term)
            2'd0:    op_b = l01_r;
            2'd1:    op_b = l11_r;
            default: op_b = sa_r;
          endcase
        end
        2'd2: begin
          case (cmd.term)
            2'd0:    op_b = l02_r;
            2'd1:    op_b = l12_r;
            default: op_b = ca_r;
          endcase
        end
        default: begin
          // Position: link translation, then the old position times one
          case (cmd.term)
            2'd0:    op_b = ang_t'(lt0_r);
            2'd1:    op_b = ang_t'(lt1_r);
            2'd2:    op_b = ang_t'(d_r);
            default: op_b = ONE_ROT;
          endcase
        end
      endcase
    end
  end

  assign prod_nxt = op_a * op_b;

  // Multiplier register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_v_r <= 1'b0;
    end else begin
      wb_v_r <= cmd.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    prod_r    <= prod_nxt;
    wb_link_r <= cmd.mul_link;
    wb_op_r   <= cmd.link_idx;
    wb_col_r  <= cmd.col;
    wb_term_r <= cmd.term;
  end

  // Write back: round link terms, accumulate frame sums
  assign prnd     = rnd_rot(prod_r);
  assign wb_base  = (wb_term_r == 2'd0) ? '0 : acc_r;
  assign wb_sum   = wb_base + ((wb_col_r == COL_POS) ? prnd : prod_r);
  assign row_done = wb_v_r && !wb_link_r && (wb_col_r == COL_POS) && (wb_term_r == 2'd3);

  always_ff @(posedge clk) begin
    if (wb_v_r) begin
      if (wb_link_r) begin
        case (wb_op_r)
          LNK_L01: l01_r <= ang_t'(-prnd);
          LNK_L02: l02_r <= ang_t'(prnd);
          LNK_L11: l11_r <= ang_t'(prnd);
          LNK_L12: l12_r <= ang_t'(-prnd);
          LNK_LT0: lt0_r <= sat32(prnd);
          LNK_LT1: lt1_r <= sat32(prnd);
          default: ;
        endcase
      end else begin
        acc_r <= wb_sum;
        if (wb_col_r != COL_POS && wb_term_r == 2'd2) begin
          nrow_r[wb_col_r] <= sat32(rnd_rot(wb_sum));
        end
      end
    end
  end

  // Frame store: identity on reset or first joint; rotates on emit or a new row
  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_ch.first_joint)) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 4; c++) begin
          frm_r[r][c] <= (r == c) ? ONE_W : '0;
        end
      end
    end else if (cmd.emit) begin
      frm_r[0] <= frm_r[1];
      frm_r[1] <= frm_r[2];
      frm_r[2] <= frm_r[0];
    end else if (row_done) begin
      frm_r[0]    <= frm_r[1];
      frm_r[1]    <= frm_r[2];
      frm_r[2][0] <= nrow_r[0];
      frm_r[2][1] <= nrow_r[1];
      frm_r[2][2] <= nrow_r[2];
      frm_r[2][3] <= sat32(wb_sum);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (cmd.emit) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      kind_r  <= cmd.emit_kind;
      row_r   <= cmd.emit_row;
      olast_r <= cmd.emit_last;
      oc0_r   <= frm_r[0][0];
      oc1_r   <= frm_r[0][1];
      oc2_r   <= frm_r[0][2];
      oc3_r   <= frm_r[0][3];
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.frame_kind  = kind_r;
  assign out_ch.row_index   = row_r;
  assign out_ch.col0        = oc0_r;
  assign out_ch.col1        = oc1_r;
  assign out_ch.col2        = oc2_r;
  assign out_ch.col3        = oc3_r;
  assign out_ch.last_result = olast_r;

endmodule

@@ design/dh_forward_kinematics_chain.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dh_forward_kinematics_chain
// Denavit-Hartenberg chain: one joint word in, three or six frame row words out.
// ----------------------------------------------------------------------------
// Sequence: the first row word is emitted from S_EMIT_PRE after accept and
//   registered in the output register; a joint then runs two 24-step passes
//   through the serial CORDIC, each after folding the angle, and 45 products
//   on the shared multiplier with 3 row drains; emits wait for a free output.
// Throughput: one joint at a time; the next joint is taken the cycle after the
//   frame update, or after the last end-effector row word is registered.
// Reset: synchronous, active low; frame returns to identity, no word pending.
module dh_forward_kinematics_chain
  import dhfk_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  dhfk_in_if.sink    in_ch,
  dhfk_out_if.source out_ch
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  dhfk_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  dhfk_datapath u_datapath (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cmd    (cmd),
    .sts    (sts)
  );

endmodule
